>>> rtl/core/ghcr_pkg.sv
// Shared constants, types and the normal-tail table for the collision risk block.
`timescale 1ns / 1ps

package ghcr_pkg;

    // Number of table intervals over the normalized argument range 0 to 4.
    localparam int TAIL_TABLE_DEPTH = 256;
    localparam int TAIL_IDX_W       = $clog2(TAIL_TABLE_DEPTH);
    // Table position: entry index plus 8 interpolation fraction bits.
    localparam int POS_W            = TAIL_IDX_W + 8;
    localparam int TAIL_SUBSTEPS    = 4;
    localparam int PANELS           = TAIL_TABLE_DEPTH * TAIL_SUBSTEPS;

    localparam int RISK_W  = 16;
    localparam int ROOT_W  = 31;
    localparam int RAD_W   = 63;
    localparam int MAG_W   = 63;

    localparam logic [RISK_W-1:0] ONE_Q15  = 16'd32768;
    localparam logic [RISK_W-1:0] HALF_Q15 = 16'd16384;
    localparam logic [RISK_W-1:0] ZERO_Q15 = 16'd0;

    localparam longint unsigned ONE_Q30         = 64'd1 << 30;
    localparam longint unsigned INV_SQRT_PI_Q30 = 64'd605793953;

    typedef enum logic [1:0] {
        CMD_CONSTRAINT    = 2'd0,
        CMD_NO_CONSTRAINT = 2'd1,
        CMD_EMPTY_LIST    = 2'd2,
        CMD_UNUSED        = 2'd3
    } cmd_t;

    typedef logic [TAIL_TABLE_DEPTH:0][RISK_W-1:0] tail_tab_t;

    // Handshake between the sequencer and an iterative unit.
    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

    // Series term divided by its order, each order with its own fixed divisor.
    function automatic longint unsigned div_by_order(input longint unsigned v,
                                                     input longint unsigned n);
        longint unsigned q;
        case (n)
            64'd1:   q = v;
            64'd2:   q = v >> 1;
            64'd3:   q = v / 64'd3;
            64'd4:   q = v >> 2;
            64'd5:   q = v / 64'd5;
            64'd6:   q = v / 64'd6;
            64'd7:   q = v / 64'd7;
            64'd8:   q = v >> 3;
            64'd9:   q = v / 64'd9;
            64'd10:  q = v / 64'd10;
            64'd11:  q = v / 64'd11;
            64'd12:  q = v / 64'd12;
            64'd13:  q = v / 64'd13;
            64'd14:  q = v / 64'd14;
            64'd15:  q = v / 64'd15;
            64'd16:  q = v >> 4;
            default: q = v;
        endcase
        return q;
    endfunction

    // exp(-w) for w in Q.30, evaluated at elaboration only.
    function automatic longint unsigned exp_neg(input longint unsigned w);
        longint unsigned f;
        longint unsigned term;
        longint unsigned e;
        longint          sum;
        longint unsigned n;
        int              i;
        f    = w >> 4;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        if (f > ONE_Q30)
        begin
            f = ONE_Q30;
        end
        for (n = 1; n <= 16; n++)
        begin
            term = div_by_order((term * f) >> 30, n);
            if (n[0])
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        e = longint'(sum);
        for (i = 0; i < 4; i++)
        begin
            e = (e * e) >> 30;
        end
        return e;
    endfunction

    function automatic longint unsigned grid_u(input longint unsigned m);
        return (m << 31) / PANELS;
    endfunction

    function automatic longint unsigned sq_q30(input longint unsigned u);
        longint unsigned h;
        h = u >> 1;
        return (h * h) >> 28;
    endfunction

    // Simpson integration of exp(-u*u) gives the tail (1 - erf(u)) / 2 in Q1.15.
    function automatic tail_tab_t build_tail_tab();
        tail_tab_t       tab;
        longint unsigned acc;
        longint unsigned g0;
        longint unsigned gm;
        longint unsigned g1;
        longint unsigned u0;
        longint unsigned um;
        longint unsigned u1;
        longint unsigned integ;
        longint unsigned d;
        longint unsigned tail;
        longint unsigned q;
        longint unsigned j;
        longint unsigned idx;
        tab    = '0;
        acc    = 0;
        g0     = exp_neg(0);
        tab[0] = HALF_Q15;
        for (j = 0; j < PANELS; j++)
        begin
            u0  = grid_u(2 * j);
            um  = grid_u(2 * j + 1);
            u1  = grid_u(2 * j + 2);
            gm  = exp_neg(sq_q30(um));
            g1  = exp_neg(sq_q30(u1));
            acc = acc + (((u1 - u0) * (g0 + 4 * gm + g1)) >> 10);
            g0  = g1;
            if (((j + 1) % TAIL_SUBSTEPS) == 0)
            begin
                integ = (acc / 6) >> 20;
                d     = (integ * INV_SQRT_PI_Q30) >> 30;
                tail  = (d >= (ONE_Q30 >> 1)) ? 64'd0 : (ONE_Q30 >> 1) - d;
                idx   = (j + 1) / TAIL_SUBSTEPS;
                q     = (tail + 64'd16384) >> 15;
                if (q > 64'd32768)
                begin
                    q = 64'd32768;
                end
                if (idx <= TAIL_TABLE_DEPTH)
                begin
                    tab[idx] = q[RISK_W-1:0];
                end
            end
        end
        return tab;
    endfunction

    localparam tail_tab_t TAIL_TAB = build_tail_tab();

endpackage

>>> rtl/core/ghcr_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module ghcr_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ghcr_pkg::unit_ctl_t        ctl_in,
    output ghcr_pkg::unit_ctl_t        ctl_out,
    input  logic [ghcr_pkg::RAD_W-1:0] radicand,
    output logic [ghcr_pkg::ROOT_W-1:0] root
);

    logic [ghcr_pkg::RAD_W-1:0] v_reg, v_next;
    logic [ghcr_pkg::RAD_W-1:0] res_reg, res_next;
    logic [ghcr_pkg::RAD_W-1:0] bit_reg, bit_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ghcr_pkg::RAD_W-1:0] trial;

    always_comb
    begin
        trial     = res_reg + bit_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl_in.start)
        begin
            v_next    = radicand;
            res_next  = '0;
            bit_next  = {1'b1, {(ghcr_pkg::RAD_W-1){1'b0}}};
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root          = res_reg[ghcr_pkg::ROOT_W-1:0];
    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;

endmodule

>>> rtl/core/ghcr_div.sv
// Iterative restoring divider that yields the table position, one bit per cycle.
`timescale 1ns / 1ps

module ghcr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ghcr_pkg::unit_ctl_t         ctl_in,
    output ghcr_pkg::unit_ctl_t         ctl_out,
    input  logic [ghcr_pkg::ROOT_W-1:0] num_hi,
    input  logic [ghcr_pkg::POS_W-1:0]  num_lo,
    input  logic [ghcr_pkg::ROOT_W-1:0] den,
    output logic [ghcr_pkg::POS_W-1:0]  quo
);

    localparam int CNT_W = $clog2(ghcr_pkg::POS_W + 1);

    logic [ghcr_pkg::ROOT_W:0]   rem_reg, rem_next;
    logic [ghcr_pkg::POS_W-1:0]  lo_reg, lo_next;
    logic [ghcr_pkg::POS_W-1:0]  q_reg, q_next;
    logic [ghcr_pkg::ROOT_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [ghcr_pkg::ROOT_W:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg[ghcr_pkg::ROOT_W-1:0], lo_reg[ghcr_pkg::POS_W-1]};
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl_in.start)
        begin
            rem_next  = {1'b0, num_hi};
            lo_next   = num_lo;
            q_next    = '0;
            den_next  = den;
            cnt_next  = CNT_W'(ghcr_pkg::POS_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            lo_next = lo_reg << 1;
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                q_next   = {q_reg[ghcr_pkg::POS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[ghcr_pkg::POS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign quo           = q_reg;
    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;

endmodule

>>> rtl/core/gaussian_halfplane_collision_risk.sv
// Top level of the Gaussian half-plane collision risk block: sequencer and shared multiplier.
`timescale 1ns / 1ps

// Each constraint item carries a Gaussian pose and one half-plane a1*x + a2*y <= b of an
// obstacle; the block returns the probability that the pose lies in it, (1 - erf(z)) / 2
// with z = t / sqrt(2 * a'Sa), and keeps the minimum over the constraints of an obstacle.
// A result item (risk, Q1.15, 32768 is 1.0) is sent when the last constraint of an
// obstacle arrives, when an obstacle without constraints is announced (1.0), or when the
// obstacle list is empty (0.0); the unused command code is dropped silently.
// The block works on one item at a time and holds in_ready low while busy. A constraint
// item passes through these steps in order: the shared 33 by 33 bit multiplier forms t;
// the larger normal component loses one bit per cycle until it fits in 14 bits (up to
// 18), and the loop is left; the multiplier forms a'Sa; the square-root unit runs (32
// iterations and the hand-back); a check catches a zero or saturated argument; the
// divider runs (one iteration per bit of the table position, 16 with the default table,
// and the hand-back); the table lookup and interpolation follow; then the minimum; and
// the output register is loaded when the constraint is the last of its obstacle. A zero
// or saturated argument skips the divider and the lookup. Commands without arithmetic go
// straight to the output register. A finished result waits in an output register, and
// the next item is taken meanwhile; a further result waits with in_ready low until that
// register is free.
module gaussian_halfplane_collision_risk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic [30:0]        var_x,
    input  logic [30:0]        var_y,
    input  logic signed [31:0] covar_xy,
    input  logic signed [31:0] coef_a1,
    input  logic signed [31:0] coef_a2,
    input  logic signed [31:0] offset_b,
    input  logic               last_in_obstacle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        risk
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MULT  = 10'b0000000010,
        S_NORM  = 10'b0000000100,
        S_MULS  = 10'b0000001000,
        S_SQRT  = 10'b0000010000,
        S_CHECK = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_LOOK  = 10'b0010000000,
        S_RISK  = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    localparam int IDX_W = ghcr_pkg::TAIL_IDX_W;
    localparam int POS_W = ghcr_pkg::POS_W;
    localparam int RW    = ghcr_pkg::RISK_W;

    state_t state_reg, state_next;

    // Latched item.
    logic signed [31:0] x_reg, y_reg, cxy_reg, a1_reg, a2_reg, b_reg;
    logic [30:0]        vx_reg, vy_reg;
    logic               last_reg;
    logic signed [31:0] x_next, y_next, cxy_next, a1_next, a2_next, b_next;
    logic [30:0]        vx_next, vy_next;
    logic               last_next;

    // Arithmetic state.
    logic [2:0]                    step_reg, step_next;
    logic signed [65:0]            prod_reg;
    logic signed [32:0]            mul_a, mul_b;
    logic signed [63:0]            t_reg, t_next;
    logic signed [63:0]            s_reg, s_next;
    logic signed [63:0]            t_sum, s_sum;
    logic                          neg_reg, neg_next;
    logic [ghcr_pkg::MAG_W-1:0]    tm_reg, tm_next;
    logic [31:0]                   m1_reg, m1_next, m2_reg, m2_next;
    logic [ghcr_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [RW-1:0]                 tail_reg, tail_next;
    logic [RW-1:0]                 min_reg, min_next;
    logic [RW-1:0]                 emit_reg, emit_next;
    logic [RW-1:0]                 res_reg, res_next;
    logic [RW-1:0]                 risk_val;
    logic                          out_valid_reg, out_valid_next;

    logic signed [32:0]            r1, r2;
    logic [31:0]                   mx;

    // Table lookup and interpolation.
    logic [IDX_W-1:0] idx;
    logic [IDX_W:0]   idx_hi, idx_lo;
    logic [7:0]       frac;
    logic [RW-1:0]    tab_hi, tab_lo, diff;
    logic [RW+7:0]    scaled;

    // Iterative units.
    ghcr_pkg::unit_ctl_t          sqrt_in, sqrt_out, div_in, div_out;
    logic [ghcr_pkg::RAD_W-1:0]   radicand;
    logic [ghcr_pkg::ROOT_W-1:0]  root;
    logic [ghcr_pkg::ROOT_W-1:0]  div_hi;
    logic [POS_W-1:0]             div_lo;
    logic [POS_W-1:0]             quo;

    // Product divided by 4, truncating toward zero.
    function automatic logic signed [63:0] quarter(input logic signed [65:0] p);
        logic signed [65:0] q;
        q = (p < 0) ? -((-p) >>> 2) : (p >>> 2);
        return q[63:0];
    endfunction

    function automatic logic [ghcr_pkg::MAG_W-1:0] MAG_W_T(input logic signed [63:0] v);
        return v[ghcr_pkg::MAG_W-1:0];
    endfunction

    ghcr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (sqrt_in),
        .ctl_out  (sqrt_out),
        .radicand (radicand),
        .root     (root)
    );

    ghcr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (div_in),
        .ctl_out (div_out),
        .num_hi  (div_hi),
        .num_lo  (div_lo),
        .den     (root_reg),
        .quo     (quo)
    );

    // The normal components cut to 14 magnitude bits, with their signs restored.
    assign r1 = a1_reg[31] ? -$signed({19'd0, m1_reg[13:0]}) : $signed({19'd0, m1_reg[13:0]});
    assign r2 = a2_reg[31] ? -$signed({19'd0, m2_reg[13:0]}) : $signed({19'd0, m2_reg[13:0]});
    assign mx = (m1_reg > m2_reg) ? m1_reg : m2_reg;

    assign t_sum = t_reg + quarter(prod_reg);
    assign s_sum = s_reg + prod_reg[63:0];

    assign radicand = {s_next[61:0], 1'b0};
    assign div_hi   = tm_reg[ghcr_pkg::ROOT_W+7:8];
    assign div_lo   = {tm_reg[7:0], {IDX_W{1'b0}}};

    assign idx    = pos_reg[POS_W-1:8];
    assign frac   = pos_reg[7:0];
    assign idx_hi = {1'b0, idx};
    assign idx_lo = {1'b0, idx} + 1'b1;
    assign tab_hi = ghcr_pkg::TAIL_TAB[idx_hi];
    assign tab_lo = ghcr_pkg::TAIL_TAB[idx_lo];
    assign diff   = (tab_hi > tab_lo) ? (tab_hi - tab_lo) : '0;
    assign scaled = diff * frac;

    assign risk_val = neg_reg ? (ghcr_pkg::ONE_Q15 - tail_reg) : tail_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MULT)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = 33'(a1_reg);
                    mul_b = 33'(x_reg);
                end
                default:
                begin
                    mul_a = 33'(a2_reg);
                    mul_b = 33'(y_reg);
                end
            endcase
        end
        else if (state_reg == S_MULS)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = r1;
                    mul_b = r1;
                end
                3'd1:
                begin
                    mul_a = prod_reg[32:0];
                    mul_b = $signed({2'b00, vx_reg});
                end
                3'd2:
                begin
                    mul_a = r2;
                    mul_b = r2;
                end
                3'd3:
                begin
                    mul_a = prod_reg[32:0];
                    mul_b = $signed({2'b00, vy_reg});
                end
                3'd4:
                begin
                    mul_a = r1;
                    mul_b = r2;
                end
                3'd5:
                begin
                    // Twice r1*r2 for the cross term.
                    mul_a = {prod_reg[31:0], 1'b0};
                    mul_b = 33'(cxy_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cxy_next       = cxy_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        b_next         = b_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        neg_next       = neg_reg;
        tm_next        = tm_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        root_next      = root_reg;
        pos_next       = pos_reg;
        tail_next      = tail_reg;
        min_next       = min_reg;
        emit_next      = emit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        sqrt_in        = '0;
        div_in         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = pose_x;
                    y_next    = pose_y;
                    cxy_next  = covar_xy;
                    a1_next   = coef_a1;
                    a2_next   = coef_a2;
                    b_next    = offset_b;
                    vx_next   = var_x;
                    vy_next   = var_y;
                    last_next = last_in_obstacle;
                    step_next = '0;
                    case (ghcr_pkg::cmd_t'(command))
                        ghcr_pkg::CMD_CONSTRAINT:
                        begin
                            state_next = S_MULT;
                        end
                        ghcr_pkg::CMD_NO_CONSTRAINT:
                        begin
                            min_next   = ghcr_pkg::ONE_Q15;
                            emit_next  = ghcr_pkg::ONE_Q15;
                            state_next = S_EMIT;
                        end
                        ghcr_pkg::CMD_EMPTY_LIST:
                        begin
                            min_next   = ghcr_pkg::ONE_Q15;
                            emit_next  = ghcr_pkg::ZERO_Q15;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_MULT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd1)
                begin
                    t_next = quarter(prod_reg) - (64'(b_reg) <<< 14);
                end
                else if (step_reg == 3'd2)
                begin
                    t_next     = t_sum;
                    neg_next   = t_sum[63];
                    tm_next    = t_sum[63] ? MAG_W_T(-t_sum) : MAG_W_T(t_sum);
                    m1_next    = a1_reg[31] ? 32'(-33'(a1_reg)) : 32'(a1_reg);
                    m2_next    = a2_reg[31] ? 32'(-33'(a2_reg)) : 32'(a2_reg);
                    state_next = S_NORM;
                end
            end

            S_NORM:
            begin
                // One bit per cycle until both components fit in 14 magnitude bits.
                if (mx >= 32'd16384)
                begin
                    m1_next = m1_reg >> 1;
                    m2_next = m2_reg >> 1;
                    tm_next = tm_reg >> 1;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_MULS;
                end
            end

            S_MULS:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    3'd2:
                    begin
                        s_next = prod_reg[63:0];
                    end
                    3'd4:
                    begin
                        s_next = s_sum;
                    end
                    3'd6:
                    begin
                        // A negative variance term is clamped to zero.
                        s_next        = s_sum[63] ? '0 : s_sum;
                        sqrt_in.start = 1'b1;
                        state_next    = S_SQRT;
                    end
                    default:
                    begin
                        s_next = s_reg;
                    end
                endcase
            end

            S_SQRT:
            begin
                if (sqrt_out.done)
                begin
                    root_next  = root;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (tm_reg == '0)
                begin
                    // A zero argument reads as one half whatever the sign.
                    tail_next  = ghcr_pkg::HALF_Q15;
                    neg_next   = 1'b0;
                    state_next = S_RISK;
                end
                else if (tm_reg >= {24'd0, root_reg, 8'd0})
                begin
                    // Argument of four or more, or a zero denominator.
                    tail_next  = ghcr_pkg::ZERO_Q15;
                    state_next = S_RISK;
                end
                else
                begin
                    div_in.start = 1'b1;
                    state_next   = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_out.done)
                begin
                    pos_next   = quo;
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                tail_next  = tab_hi - scaled[RW+7:8];
                state_next = S_RISK;
            end

            S_RISK:
            begin
                if (risk_val < min_reg)
                begin
                    min_next = risk_val;
                end
                if (last_reg)
                begin
                    emit_next  = (risk_val < min_reg) ? risk_val : min_reg;
                    min_next   = ghcr_pkg::ONE_Q15;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                // The output register is loaded only once its previous item has left.
                if (!out_valid_reg || out_ready)
                begin
                    res_next       = emit_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            min_reg       <= ghcr_pkg::ONE_Q15;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        cxy_reg  <= cxy_next;
        a1_reg   <= a1_next;
        a2_reg   <= a2_next;
        b_reg    <= b_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        last_reg <= last_next;
        prod_reg <= mul_a * mul_b;
        t_reg    <= t_next;
        s_reg    <= s_next;
        neg_reg  <= neg_next;
        tm_reg   <= tm_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        root_reg <= root_next;
        pos_reg  <= pos_next;
        tail_reg <= tail_next;
        emit_reg <= emit_next;
        res_reg  <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign risk      = res_reg;

endmodule
